>>> rtl/salhs_pkg.sv
// ----------------------------------------------------------------------------
// salhs_pkg - shared types and constants for the Salsa20 / HSalsa20 core
// State word types, request and response words, quarter-round index tables
// and the initial-state builder.
// ----------------------------------------------------------------------------
`default_nettype none

package salhs_pkg;

	localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
	localparam int unsigned STEPS_PER_DR      = 8;

	typedef logic [31:0] word_t;
	typedef logic [63:0] dword_t;
	typedef word_t [15:0] state_t;
	typedef dword_t [3:0] key_t;
	typedef logic [3:0] widx_t;

	// opcode values
	localparam logic OP_HSALSA = 1'b0;
	localparam logic OP_BLOCK  = 1'b1;

	// register indexes on the configuration port
	localparam logic [1:0] REG_KEY0 = 2'd0;
	localparam logic [1:0] REG_KEY1 = 2'd1;
	localparam logic [1:0] REG_KEY2 = 2'd2;
	localparam logic [1:0] REG_KEY3 = 2'd3;

	// "expand 32-byte k"
	localparam word_t SIGMA0 = 32'h6170_7865;
	localparam word_t SIGMA1 = 32'h3320_646e;
	localparam word_t SIGMA2 = 32'h7962_2d32;
	localparam word_t SIGMA3 = 32'h6b20_6574;

	// quarter-round word indexes (a, b, c, d): column round, then row round
	localparam widx_t QR_IDX [2][4][4] = '{
		'{ '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
		   '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11} },
		'{ '{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
		   '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14} }
	};

	localparam int unsigned ROT_AMT [4] = '{7, 9, 13, 18};

	// HSalsa20 output word order
	localparam widx_t HS_PICK [8] = '{4'd0, 4'd5, 4'd10, 4'd15, 4'd6, 4'd7, 4'd8, 4'd9};

	typedef struct packed {
		logic   opcode;
		dword_t nonce_low;
		dword_t nonce_high;
		dword_t block_counter;
	} req_t;

	typedef struct packed {
		dword_t     output_word;
		logic [2:0] word_index;
		logic       last_word;
	} rsp_t;

	// what travels along the round chain
	typedef struct packed {
		logic   mode;
		state_t st;
		dword_t n_lo;
		dword_t n_mid;
	} cell_pay_t;

	function automatic word_t rotl(word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic state_t init_state(key_t key, dword_t n_lo, dword_t n_mid);
		state_t s;
		s[0]  = SIGMA0;
		s[1]  = key[0][31:0];
		s[2]  = key[0][63:32];
		s[3]  = key[1][31:0];
		s[4]  = key[1][63:32];
		s[5]  = SIGMA1;
		s[6]  = n_lo[31:0];
		s[7]  = n_lo[63:32];
		s[8]  = n_mid[31:0];
		s[9]  = n_mid[63:32];
		s[10] = SIGMA2;
		s[11] = key[2][31:0];
		s[12] = key[2][63:32];
		s[13] = key[3][31:0];
		s[14] = key[3][63:32];
		s[15] = SIGMA3;
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/salhs_cell.sv
// ----------------------------------------------------------------------------
// salhs_cell - one quarter-round step across all four quarters
// Applies one add-rotate-xor to four disjoint words and hands the state on.
// ----------------------------------------------------------------------------
`default_nettype none

module salhs_cell #(
	parameter int unsigned STEP = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  valid_i,
	input  salhs_pkg::cell_pay_t pay_i,
	output logic                 valid_o,
	output salhs_pkg::cell_pay_t pay_o
);
	import salhs_pkg::*;

	localparam int unsigned HALF = (STEP % STEPS_PER_DR) / 4;
	localparam int unsigned SUB  = STEP % 4;
	localparam int unsigned TGT  = (SUB + 1) % 4;
	localparam int unsigned SRCB = (SUB + 3) % 4;

	cell_pay_t nxt;
	logic      valid_q;
	cell_pay_t pay_q;

	always_comb begin
		nxt = pay_i;
		for (int q = 0; q < 4; q++) begin
			nxt.st[QR_IDX[HALF][q][TGT]] = pay_i.st[QR_IDX[HALF][q][TGT]] ^
				rotl(pay_i.st[QR_IDX[HALF][q][SUB]] + pay_i.st[QR_IDX[HALF][q][SRCB]],
					ROT_AMT[SUB]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nxt;
		end
	end

	assign valid_o = valid_q;
	assign pay_o   = pay_q;

endmodule

`default_nettype wire

>>> rtl/salhs_outq.sv
// ----------------------------------------------------------------------------
// salhs_outq - result buffer and word serializer
// Takes a finished state, forms the output words and hands them out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module salhs_outq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  fin_valid,
	input  salhs_pkg::cell_pay_t fin_pay,
	input  salhs_pkg::key_t      key,
	output logic                 load,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output salhs_pkg::rsp_t      rsp
);
	import salhs_pkg::*;

	dword_t     words_q [8];
	dword_t     new_words [8];
	logic [2:0] idx_q;
	logic       busy_q;
	logic       hs_q;
	logic       is_last;
	logic       fire;
	state_t     init;

	assign is_last = hs_q ? (idx_q == 3'd3) : (idx_q == 3'd7);
	assign fire    = busy_q && !rsp_stall;
	assign load    = fin_valid && (!busy_q || (fire && is_last));
	assign init    = init_state(key, fin_pay.n_lo, fin_pay.n_mid);

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			if (fin_pay.mode == OP_BLOCK) begin
				new_words[k] = {fin_pay.st[2 * k + 1] + init[2 * k + 1],
					fin_pay.st[2 * k] + init[2 * k]};
			end else if (k < 4) begin
				new_words[k] = {fin_pay.st[HS_PICK[2 * k + 1]], fin_pay.st[HS_PICK[2 * k]]};
			end else begin
				new_words[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			hs_q   <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			hs_q   <= (fin_pay.mode == OP_HSALSA);
		end else if (fire) begin
			busy_q <= !is_last;
			idx_q  <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= new_words;
		end
	end

	assign rsp_valid        = busy_q;
	assign rsp.output_word  = words_q[idx_q];
	assign rsp.word_index   = idx_q;
	assign rsp.last_word    = is_last;

endmodule

`default_nettype wire

>>> rtl/salsa20_hsalsa20_core.sv
// ----------------------------------------------------------------------------
// salsa20_hsalsa20_core - Salsa20/20 block and HSalsa20 subkey engine
// Key in four 64-bit registers; each request runs the double rounds down a
// chain of step cells and leaves as four or eight 64-bit words.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              word
//  -------  ---------  ---------------------  -------------------------------
//  req      in         req_valid / req_stall  opcode, nonce, block counter
//  rsp      out        rsp_valid / rsp_stall  64-bit word, index, last flag
//  apb      in/out     psel/penable/pready    key_part_0..3 at 0x00..0x18
//
// Each request walks 8*DOUBLE_ROUNDS step cells, the first step computed
// in the cycle of acceptance; the finished state then loads into the
// result buffer when that buffer is idle or handing out its last word,
// and the words are offered from the buffer's registers.
// The result port gives one word per cycle while rsp_stall is low; a Salsa20
// block takes eight words and an HSalsa20 request four, which sets the rate.
// When the finished state cannot enter the result buffer the whole chain
// holds and req_stall rises; otherwise a new request enters every cycle.
// Reset clears the key registers, chain valid bits and buffer control state.
// ----------------------------------------------------------------------------
`default_nettype none

module salsa20_hsalsa20_core #(
	parameter int unsigned DOUBLE_ROUNDS = salhs_pkg::DOUBLE_ROUNDS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	// request channel
	input  wire               req_valid,
	output logic              req_stall,
	input  salhs_pkg::req_t   req,
	// result channel
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output salhs_pkg::rsp_t   rsp,
	// configuration port
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [4:0]        paddr,
	input  wire  [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	import salhs_pkg::*;

	localparam int unsigned NCELL = STEPS_PER_DR * DOUBLE_ROUNDS;

	key_t      key_q;
	logic      cfg_wr;
	logic      en;
	logic      load;
	logic      vld [NCELL + 1];
	cell_pay_t pay [NCELL + 1];
	dword_t    mid;

	// ---- configuration registers ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_KEY0: key_q[0] <= pwdata;
				REG_KEY1: key_q[1] <= pwdata;
				REG_KEY2: key_q[2] <= pwdata;
				REG_KEY3: key_q[3] <= pwdata;
				default:  key_q[0] <= key_q[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_KEY0: prdata = key_q[0];
			REG_KEY1: prdata = key_q[1];
			REG_KEY2: prdata = key_q[2];
			REG_KEY3: prdata = key_q[3];
			default:  prdata = '0;
		endcase
	end

	// ---- chain entry: build the initial state ----
	// Advance the chain unless a finished state is stuck at its end.
	assign en        = !vld[NCELL] || load;
	assign req_stall = !en;

	assign mid    = (req.opcode == OP_BLOCK) ? req.block_counter : req.nonce_high;
	assign vld[0] = req_valid;
	assign pay[0] = {req.opcode, init_state(key_q, req.nonce_low, mid), req.nonce_low, mid};

	// ---- round chain: eight step cells per double round ----
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		salhs_cell #(
			.STEP (i % STEPS_PER_DR)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (vld[i]),
			.pay_i   (pay[i]),
			.valid_o (vld[i + 1]),
			.pay_o   (pay[i + 1])
		);
	end

	// ---- final add (Salsa20 blocks) and word output ----
	salhs_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (vld[NCELL]),
		.fin_pay   (pay[NCELL]),
		.key       (key_q),
		.load      (load),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

>>> rtl/salhs_checker.sv
// ----------------------------------------------------------------------------
// salhs_checker - port-level checks for the Salsa20 / HSalsa20 core
// Watches the result channel for stalled-word stability, ordering and framing.
// ----------------------------------------------------------------------------
`default_nettype none

module salhs_checker (
	input wire             clk,
	input wire             arst_n,
	input wire             rsp_valid,
	input wire             rsp_stall,
	input salhs_pkg::rsp_t rsp
);
	import salhs_pkg::*;

	logic fire;
	assign fire = rsp_valid && !rsp_stall;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !rsp.last_word |=> rsp_valid)
		else $error("gap inside a request's words");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !rsp.last_word |=> rsp.word_index == $past(rsp.word_index) + 3'd1)
		else $error("word index out of order");

	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last_word |-> rsp.word_index == 3'd3 || rsp.word_index == 3'd7)
		else $error("last word at wrong index");

endmodule

bind salsa20_hsalsa20_core salhs_checker u_salhs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
